// ----- rtl/brat_pkg.sv -----
// Package for the bounded rational approximation block.
// Holds field widths, reset values, part codes and fixed constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package brat_pkg;

    // Field widths of the input and result transactions.
    localparam int VALUE_W = 32;
    localparam int NUM_W   = 32;
    localparam int DEN_W   = 16;
    localparam int PART_W  = 2;

    // Default number of fraction bits of the fixed-point input.
    localparam int FRACTION_BITS = 16;

    // Width of the denominator limit register.
    localparam int DENOMINATOR_BITS = 16;

    // Reset value of the denominator limit.
    localparam logic [DENOMINATOR_BITS-1:0] RESET_MAX_DEN = DENOMINATOR_BITS'(1000);

    // Minutes per degree and seconds per minute.
    localparam int SIXTY = 60;

    // Largest numerator that can be reported.
    localparam logic [NUM_W-1:0] NUM_SAT = 32'hFFFF_FFFF;

    // Part codes of a result transaction.
    localparam logic [PART_W-1:0] PART_WHOLE = 2'd0;
    localparam logic [PART_W-1:0] PART_MIN   = 2'd1;
    localparam logic [PART_W-1:0] PART_SEC   = 2'd2;

endpackage : brat_pkg

`default_nettype wire

// ----- rtl/brat_in_if.sv -----
// Input channel of the bounded rational approximation block.
// Carries valid, ready, mode and the fixed-point value; depends on brat_pkg.
`default_nettype none

interface brat_in_if;
    import brat_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);

endinterface : brat_in_if

`default_nettype wire

// ----- rtl/brat_out_if.sv -----
// Result channel of the bounded rational approximation block.
// Carries valid, ready and one numerator/denominator pair; depends on brat_pkg.
`default_nettype none

interface brat_out_if;
    import brat_pkg::*;

    logic              valid;
    logic              ready;
    logic [NUM_W-1:0]  numerator;
    logic [DEN_W-1:0]  denominator;
    logic [PART_W-1:0] part;
    logic              not_positive;
    logic              last;

    modport source (output valid, output numerator, output denominator, output part,
                    output not_positive, output last, input ready);
    modport sink   (input valid, input numerator, input denominator, input part,
                    input not_positive, input last, output ready);

endinterface : brat_out_if

`default_nettype wire

// ----- rtl/bounded_rational_approximation_top.sv -----
// Top level of the bounded rational approximation block.
// Depends on brat_pkg, brat_in_if and brat_out_if.
`default_nettype none

// Each input transaction is a signed fixed-point value; the block reports its
// magnitude as numerator/denominator with the denominator no larger than the
// max_denominator register (a written zero acts as one), plus a flag for a
// zero or negative input. In mode 1 the magnitude is split into degrees,
// minutes and seconds and three results come out, the last one flagged.
// The work runs on one restoring divider (one quotient bit per cycle) and one
// multiply-add unit under a small sequencer. For each part the first term
// comes from a shift; each further continued-fraction term that fits the
// limit takes a divide and multiply-add steps for the denominator and the
// numerator. When the limit stops the expansion after the divide of the term
// that does not fit, a divide of the semiconvergent follows, and the part is
// put out. The block takes no new input until the last result of the current
// one has been loaded into the output register, which then waits for the sink
// independently; a part whose result is ready waits while that register is
// still full.
module bounded_rational_approximation_top
#(
    parameter int FRACTION_BITS = brat_pkg::FRACTION_BITS
)
(
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  wire                                       cfg_we,
    input  wire [brat_pkg::DENOMINATOR_BITS-1:0]      cfg_wdata,
    brat_in_if.sink                                   sample,
    brat_out_if.source                                result
);
    import brat_pkg::*;

    // Derived widths.
    localparam int DIV_W = (FRACTION_BITS + 1 > DENOMINATOR_BITS) ?
                           FRACTION_BITS + 1 : DENOMINATOR_BITS;
    localparam int H_W   = VALUE_W - FRACTION_BITS + DENOMINATOR_BITS + 1;
    localparam int M_W   = H_W + DIV_W;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int T_W   = FRACTION_BITS + 6;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MULK  = 3'd3;
    localparam logic [2:0] S_MULH  = 3'd4;
    localparam logic [2:0] S_SEMK  = 3'd5;
    localparam logic [2:0] S_SEMH  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic [DENOMINATOR_BITS-1:0] max_den_reg;
    logic                        mode_reg, mode_next;
    logic                        np_reg, np_next;
    logic [VALUE_W-1:0]          mag_reg, mag_next;
    logic [PART_W-1:0]           part_reg, part_next;
    logic                        semi_reg, semi_next;
    logic [H_W-1:0]              h_reg, h_next;
    logic [H_W-1:0]              hp_reg, hp_next;
    logic [DEN_W-1:0]            k_reg, k_next;
    logic [DEN_W-1:0]            kp_reg, kp_next;
    logic [DIV_W-1:0]            quo_reg, quo_next;
    logic [DIV_W-1:0]            rem_reg, rem_next;
    logic [DIV_W-1:0]            den_reg, den_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    logic                        out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]            out_num_reg, out_num_next;
    logic [DEN_W-1:0]            out_den_reg, out_den_next;
    logic [PART_W-1:0]           out_part_reg, out_part_next;
    logic                        out_np_reg, out_np_next;
    logic                        out_last_reg, out_last_next;

    logic [DEN_W-1:0]            lim;
    logic                        in_neg;
    logic [VALUE_W-1:0]          in_mag;
    logic [FRACTION_BITS-1:0]    frac;
    logic [T_W-1:0]              t60;
    logic [T_W-1:0]              secs;
    logic [VALUE_W-1:0]          part_p;
    logic [H_W-1:0]              a0;
    logic [FRACTION_BITS-1:0]    r0;
    logic [DIV_W:0]              rem_sh;
    logic [DIV_W+1:0]            diff;
    logic [H_W-1:0]              mul_x;
    logic [H_W-1:0]              mul_add;
    logic [M_W-1:0]              mul_prod;
    logic [M_W:0]                mul_sum;
    logic                        mul_over;
    logic [H_W+NUM_W-1:0]        h_ext;
    logic                        last_part;
    logic                        out_free;

    // Effective denominator limit; zero acts as one.
    assign lim = (max_den_reg == '0) ? DEN_W'(1) : DEN_W'(max_den_reg);

    // Magnitude of the incoming value; the most negative value maps to 2^31.
    assign in_neg = sample.value[VALUE_W-1];
    assign in_mag = in_neg ? (VALUE_W'(0) - VALUE_W'(sample.value)) : VALUE_W'(sample.value);

    // Minutes and seconds of the stored magnitude.
    assign frac = mag_reg[FRACTION_BITS-1:0];
    assign t60  = T_W'(frac) * T_W'(SIXTY);
    assign secs = T_W'(t60[FRACTION_BITS-1:0]) * T_W'(SIXTY);

    // Select the fixed-point value of the current part.
    always_comb
    begin
        case (part_reg)
            PART_WHOLE: part_p = mode_reg ?
                                 {mag_reg[VALUE_W-1:FRACTION_BITS], {FRACTION_BITS{1'b0}}} :
                                 mag_reg;
            PART_MIN:   part_p = VALUE_W'(t60[T_W-1:FRACTION_BITS]) << FRACTION_BITS;
            PART_SEC:   part_p = VALUE_W'(secs);
            default:    part_p = '0;
        endcase
    end

    // First term: division by 2^FRACTION_BITS is a shift and a mask.
    assign a0 = H_W'(part_p >> FRACTION_BITS);
    assign r0 = part_p[FRACTION_BITS-1:0];

    // One restoring divider step.
    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, den_reg};

    // Shared multiply-add: x * quotient + addend.
    always_comb
    begin
        if (state_reg == S_MULH || state_reg == S_SEMH)
        begin
            mul_x   = h_reg;
            mul_add = hp_reg;
        end
        else
        begin
            mul_x   = H_W'(k_reg);
            mul_add = H_W'(kp_reg);
        end
    end

    assign mul_prod = M_W'(mul_x) * M_W'(quo_reg);
    assign mul_sum  = {1'b0, mul_prod} + (M_W + 1)'(mul_add);
    assign mul_over = mul_sum > (M_W + 1)'(lim);

    // Numerator saturation, last-part flag and output register free test.
    assign h_ext     = (H_W + NUM_W)'(h_reg);
    assign last_part = !mode_reg || (part_reg == PART_SEC);
    assign out_free  = !out_valid_reg || result.ready;

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        np_next        = np_reg;
        mag_next       = mag_reg;
        part_next      = part_reg;
        semi_next      = semi_reg;
        h_next         = h_reg;
        hp_next        = hp_reg;
        k_next         = k_reg;
        kp_next        = kp_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_part_next  = out_part_reg;
        out_np_next    = out_np_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    mode_next  = sample.mode;
                    np_next    = in_neg || (sample.value == '0);
                    mag_next   = in_mag;
                    part_next  = PART_WHOLE;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                // The first convergent a0/1 always fits the limit.
                h_next    = a0;
                hp_next   = H_W'(1);
                k_next    = DEN_W'(1);
                kp_next   = '0;
                semi_next = 1'b0;
                if (r0 == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    quo_next   = DIV_W'(1) << FRACTION_BITS;
                    den_next   = DIV_W'(r0);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (!diff[DIV_W+1])
                begin
                    rem_next = diff[DIV_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DIV_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    state_next = semi_reg ? S_SEMK : S_MULK;
                end
            end

            S_MULK:
            begin
                if (mul_over)
                begin
                    // Limit reached: divide (lim - kp) by k for the semiconvergent.
                    semi_next  = 1'b1;
                    quo_next   = DIV_W'(lim - kp_reg);
                    den_next   = DIV_W'(k_reg);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    k_next     = mul_sum[DEN_W-1:0];
                    kp_next    = k_reg;
                    state_next = S_MULH;
                end
            end

            S_MULH:
            begin
                h_next  = mul_sum[H_W-1:0];
                hp_next = h_reg;
                if (rem_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    // Next Euclid step: old divisor over remainder.
                    quo_next   = den_reg;
                    den_next   = rem_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end

            S_SEMK:
            begin
                k_next     = mul_sum[DEN_W-1:0];
                state_next = S_SEMH;
            end

            S_SEMH:
            begin
                h_next     = mul_sum[H_W-1:0];
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = (|(h_ext >> NUM_W)) ? NUM_SAT : h_ext[NUM_W-1:0];
                    out_den_next   = k_reg;
                    out_part_next  = part_reg;
                    out_np_next    = np_reg;
                    out_last_next  = last_part;
                    if (last_part)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        part_next  = part_reg + PART_W'(1);
                        state_next = S_START;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            max_den_reg   <= RESET_MAX_DEN;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                max_den_reg <= cfg_wdata;
            end
        end
    end

    // Datapath and output payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        np_reg       <= np_next;
        mag_reg      <= mag_next;
        part_reg     <= part_next;
        semi_reg     <= semi_next;
        h_reg        <= h_next;
        hp_reg       <= hp_next;
        k_reg        <= k_next;
        kp_reg       <= kp_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        cnt_reg      <= cnt_next;
        out_num_reg  <= out_num_next;
        out_den_reg  <= out_den_next;
        out_part_reg <= out_part_next;
        out_np_reg   <= out_np_next;
        out_last_reg <= out_last_next;
    end

    // Channel outputs.
    assign sample.ready        = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.numerator    = out_num_reg;
    assign result.denominator  = out_den_reg;
    assign result.part         = out_part_reg;
    assign result.not_positive = out_np_reg;
    assign result.last         = out_last_reg;

endmodule : bounded_rational_approximation_top

`default_nettype wire
